// ===== rtl/krt_pkg.sv =====
// Package for the keyed record table: item structs, action and status codes,
// controller states and the default table size. No dependencies.
package krt_pkg;

  localparam int unsigned CapacityDefault = 64;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_MODIFY = 3'd2,
    ACT_LOOKUP = 3'd3,
    ACT_SORT   = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_READ   = 3'd6
  } krt_action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_CLASS = 3'd4,
    ST_BAD_INDEX = 3'd5
  } krt_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN2,
    S_SHIFT,
    S_SORT,
    S_SWAP_A,
    S_SWAP_B,
    S_RD_WAIT,
    S_DONE
  } krt_state_e;

  typedef struct packed {
    krt_action_e action;
    logic [30:0] key_id;
    logic [30:0] new_id;
    logic [1:0]  class_code;
    logic        descending;
    logic [5:0]  read_index;
  } krt_in_t;

  typedef struct packed {
    krt_status_e status;
    logic [5:0]  found_index;
    logic [30:0] record_id;
    logic [1:0]  record_class;
    logic [6:0]  entry_total;
  } krt_out_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [30:0] id;
    logic [1:0]  cls;
  } krt_rec_t;

endpackage

// ===== rtl/krt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/krt_ctrl.sv =====
// Table sequencer: scans, shifts, selection sort and reads over the record RAM.
// Depends on krt_pkg; drives the RAM ports of krt_ram.
module krt_ctrl import krt_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  krt_in_t                     in_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output krt_out_t                    res_item_o,
  output logic                        ram_we_o,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr_o,
  output krt_rec_t                    ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_o,
  input  krt_rec_t                    ram_rdata_i
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IXW = (CW > 6) ? CW : 6;

  krt_state_e  state_q, state_d;
  krt_action_e act_q, act_d;
  logic [30:0] key_q, key_d, nid_q, nid_d;
  logic [1:0]  cls_q, cls_d;
  logic        desc_q, desc_d;
  logic [CW-1:0] cnt_q, cnt_d, issue_q, issue_d;
  logic        pend_q, pend_d;
  logic [IW-1:0] cmp_q, cmp_d, pos_q, pos_d, outer_q, outer_d, pick_q, pick_d;
  krt_rec_t    best_q, best_d, orig_q, orig_d;
  krt_status_e res_st_q, res_st_d;
  logic [IW-1:0] res_idx_q, res_idx_d;
  krt_rec_t    res_rec_q, res_rec_d;

  logic more, drained, key_hit, nid_hit, better, outer_last, ridx_bad;
  logic [CW-1:0] next_outer;

  // Scan conditions: one read issued per cycle, compared in the cycle after it is issued.
  always_comb begin
    more       = issue_q < cnt_q;
    drained    = !pend_q && !more;
    key_hit    = pend_q && (ram_rdata_i.id == key_q);
    nid_hit    = pend_q && (ram_rdata_i.id == nid_q) && (cmp_q != pos_q);
    better     = desc_q ? (best_q.id < ram_rdata_i.id) : (best_q.id > ram_rdata_i.id);
    next_outer = CW'(outer_q) + CW'(1);
    outer_last = next_outer >= cnt_q;
    ridx_bad   = IXW'(in_item_i.read_index) >= IXW'(cnt_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.action)
            ACT_INSERT: state_d = (in_item_i.class_code == 2'd0) ? S_DONE : S_SCAN;
            ACT_DELETE, ACT_MODIFY, ACT_LOOKUP: state_d = S_SCAN;
            ACT_SORT:   state_d = (cnt_q == '0) ? S_DONE : S_SORT;
            ACT_READ:   state_d = ridx_bad ? S_DONE : S_RD_WAIT;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          unique case (act_q)
            ACT_DELETE: state_d = S_SHIFT;
            ACT_MODIFY: state_d = S_SCAN2;
            default:    state_d = S_DONE;
          endcase
        end else if (drained) begin
          state_d = S_DONE;
        end
      end
      S_SCAN2: if (nid_hit || drained) state_d = S_DONE;
      S_SHIFT: if (drained) state_d = S_DONE;
      S_SORT: begin
        if (drained) begin
          if (pick_q != outer_q) state_d = S_SWAP_A;
          else if (outer_last)   state_d = S_DONE;
        end
      end
      S_SWAP_A:  state_d = S_SWAP_B;
      S_SWAP_B:  state_d = outer_last ? S_DONE : S_SORT;
      S_RD_WAIT: state_d = S_DONE;
      S_DONE:    if (res_ready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    act_d = act_q; key_d = key_q; nid_d = nid_q; cls_d = cls_q; desc_d = desc_q;
    cnt_d = cnt_q; issue_d = issue_q; pend_d = pend_q; cmp_d = cmp_q;
    pos_d = pos_q; outer_d = outer_q; pick_d = pick_q; best_d = best_q; orig_d = orig_q;
    res_st_d = res_st_q; res_idx_d = res_idx_q; res_rec_d = res_rec_q;
    ram_we_o = 1'b0; ram_waddr_o = '0; ram_wdata_o = '0;
    ram_re_o = 1'b0; ram_raddr_o = issue_q[IW-1:0];

    // shared sweep: issue the next address while entries remain
    if (state_q == S_SCAN || state_q == S_SCAN2 || state_q == S_SHIFT ||
        state_q == S_SORT) begin
      pend_d = more;
      if (more) begin
        ram_re_o = 1'b1;
        issue_d  = issue_q + CW'(1);
        cmp_d    = issue_q[IW-1:0];
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_item_i.action; key_d = in_item_i.key_id; nid_d = in_item_i.new_id;
          cls_d = in_item_i.class_code; desc_d = in_item_i.descending;
          issue_d = '0; pend_d = 1'b0; outer_d = '0;
          res_st_d = ST_OK; res_idx_d = '0; res_rec_d = '0;
          unique case (in_item_i.action)
            ACT_INSERT: if (in_item_i.class_code == 2'd0) res_st_d = ST_BAD_CLASS;
            ACT_CLEAR:  cnt_d = '0;
            ACT_READ: begin
              if (ridx_bad) begin
                res_st_d = ST_BAD_INDEX;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = IW'(in_item_i.read_index);
                pos_d       = IW'(in_item_i.read_index);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          pend_d = 1'b0;
          pos_d  = cmp_q;
          unique case (act_q)
            ACT_INSERT: res_st_d = ST_DUPLICATE;
            ACT_DELETE: begin
              res_idx_d = cmp_q; res_rec_d = ram_rdata_i;
              issue_d   = CW'(cmp_q) + CW'(1);
            end
            ACT_MODIFY: issue_d = '0;
            default: begin
              res_idx_d = cmp_q; res_rec_d = ram_rdata_i;
            end
          endcase
        end else if (drained) begin
          if (act_q == ACT_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              res_st_d = ST_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cnt_q[IW-1:0];
              ram_wdata_o = '{id: key_q, cls: cls_q};
              cnt_d       = cnt_q + CW'(1);
              res_idx_d   = cnt_q[IW-1:0];
              res_rec_d   = '{id: key_q, cls: cls_q};
            end
          end else begin
            res_st_d = ST_NOT_FOUND;
          end
        end
      end
      S_SCAN2: begin
        if (nid_hit) begin
          pend_d   = 1'b0;
          res_st_d = ST_DUPLICATE;
        end else if (drained) begin
          if (cls_q == 2'd0) begin
            res_st_d = ST_BAD_CLASS;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = pos_q;
            ram_wdata_o = '{id: nid_q, cls: cls_q};
            res_idx_d   = pos_q;
            res_rec_d   = '{id: nid_q, cls: cls_q};
          end
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves one place down
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cmp_q - IW'(1);
          ram_wdata_o = ram_rdata_i;
        end
        if (drained) cnt_d = cnt_q - CW'(1);
      end
      S_SORT: begin
        if (pend_q) begin
          if (cmp_q == outer_q) begin
            orig_d = ram_rdata_i; best_d = ram_rdata_i; pick_d = outer_q;
          end else if (better) begin
            best_d = ram_rdata_i; pick_d = cmp_q;
          end
        end
        if (drained && pick_q == outer_q && !outer_last) begin
          outer_d = IW'(next_outer);
          issue_d = next_outer;
        end
      end
      S_SWAP_A: begin
        ram_we_o = 1'b1; ram_waddr_o = outer_q; ram_wdata_o = best_q;
      end
      S_SWAP_B: begin
        ram_we_o = 1'b1; ram_waddr_o = pick_q; ram_wdata_o = orig_q;
        outer_d  = IW'(next_outer);
        issue_d  = next_outer;
      end
      S_RD_WAIT: begin
        res_idx_d = pos_q; res_rec_d = ram_rdata_i;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_item_o  = '{status: res_st_q, found_index: 6'(res_idx_q),
                         record_id: res_rec_q.id, record_class: res_rec_q.cls,
                         entry_total: 7'(cnt_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      issue_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; key_q <= key_d; nid_q <= nid_d; cls_q <= cls_d; desc_q <= desc_d;
    cmp_q <= cmp_d; pos_q <= pos_d; outer_q <= outer_d; pick_q <= pick_d;
    best_q <= best_d; orig_q <= orig_d;
    res_st_q <= res_st_d; res_idx_q <= res_idx_d; res_rec_q <= res_rec_d;
  end

endmodule

// ===== rtl/keyed_record_table_top.sv =====
// Keyed record table, top level: record RAM, sequencer and output register.
// Depends on krt_pkg, krt_ram and krt_ctrl.
//
// A table of up to CAPACITY records (31-bit ID, 2-bit class) kept in one
// RAM with a single read and a single write port; every action is one
// input item and gives exactly one result item. Only one item is in work
// at a time, and the RAM read port, one entry per cycle, sets the time:
// lookup and insert scan the table at most once, delete searches for the
// key and shifts the entries above it down (the search and the shift down
// together pass over the table once), modify searches for the key, then
// checks the new ID against all others, and sort is a selection sort. A
// finished result sits in an output register, so the next item is taken
// while it waits. The RAM needs no clearing after reset: only entries
// below the record count are ever read.
module keyed_record_table_top import krt_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  krt_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output krt_out_t out_item_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  krt_rec_t      ram_wdata, ram_rdata;

  logic     res_valid, res_ready;
  krt_out_t res_item;

  logic     out_valid_q;
  krt_out_t out_item_q;

  krt_ram #(
    .WIDTH ($bits(krt_rec_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  krt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/krt_checker.sv =====
// Port-level checks for keyed_record_table_top, attached by bind.
// Depends on krt_pkg.
module krt_checker import krt_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input krt_out_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // failures carry no record
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.found_index == '0 && out_item_o.record_id == '0 &&
      out_item_o.record_class == '0)
    else $error("failed result carries a record");

  // a record shown as ok has a legal class
  a_ok_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_OK && out_item_o.record_id != '0 |->
      out_item_o.record_class != 2'd0)
    else $error("record with class zero");

  // count never exceeds the table size
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.entry_total) <= CAPACITY)
    else $error("entry total beyond capacity");

endmodule

bind keyed_record_table_top krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (.*);
